[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token kind codes, character codes and keyword tables for the
// source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  // scanner modes
  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_IDENT   = 6'b000010,
    MODE_NUMBER  = 6'b000100,
    MODE_SLASH   = 6'b001000,
    MODE_COMMENT = 6'b010000,
    MODE_OP      = 6'b100000
  } stt_mode_t;

  // token kinds
  localparam logic [4:0] K_EOF     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_INT     = 5'd2;
  localparam logic [4:0] K_IF      = 5'd3;
  localparam logic [4:0] K_DIV     = 5'd9;
  localparam logic [4:0] K_PLUS    = 5'd10;
  localparam logic [4:0] K_MINUS   = 5'd11;
  localparam logic [4:0] K_STAR    = 5'd12;
  localparam logic [4:0] K_PCT     = 5'd13;
  localparam logic [4:0] K_LBRACE  = 5'd14;
  localparam logic [4:0] K_RBRACE  = 5'd15;
  localparam logic [4:0] K_LPAREN  = 5'd16;
  localparam logic [4:0] K_RPAREN  = 5'd17;
  localparam logic [4:0] K_COMMA   = 5'd18;
  localparam logic [4:0] K_AMP     = 5'd19;
  localparam logic [4:0] K_QUEST   = 5'd20;
  localparam logic [4:0] K_NOT     = 5'd21;
  localparam logic [4:0] K_UNKNOWN = 5'd29;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;

  // pending two-character operator codes
  localparam logic [1:0] POP_BANG = 2'd0;
  localparam logic [1:0] POP_EQ   = 2'd1;
  localparam logic [1:0] POP_GT   = 2'd2;
  localparam logic [1:0] POP_LT   = 2'd3;

  // keywords: if else while break int bool
  localparam int KW_NUM = 6;
  localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
    '{0: "i", 1: "f", default: 8'h00},
    '{0: "e", 1: "l", 2: "s", 3: "e", default: 8'h00},
    '{0: "w", 1: "h", 2: "i", 3: "l", 4: "e", default: 8'h00},
    '{0: "b", 1: "r", 2: "e", 3: "a", 4: "k", default: 8'h00},
    '{0: "i", 1: "n", 2: "t", default: 8'h00},
    '{0: "b", 1: "o", 2: "o", 3: "l", default: 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd2, 3'd4, 3'd5, 3'd5, 3'd3, 3'd4};

  // one token as it leaves the block
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [7:0]  len;
    logic        last;
  } stt_tok_t;

  // single-character operator lookup result
  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } stt_op_t;

  // two-character operator lookup result
  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } stt_pair_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // keywords that still agree with character c at position pos
  function automatic logic [KW_NUM-1:0] kw_match(logic [7:0] c, logic [2:0] pos);
    logic [KW_NUM-1:0] m;
    for (int k = 0; k < KW_NUM; k++) begin
      m[k] = (pos < KW_LEN[k]) && (KW_TEXT[k][pos] == c);
    end
    return m;
  endfunction

  // identifier kind from the live keyword mask and a short length
  function automatic logic [4:0] kw_kind(logic [KW_NUM-1:0] alive, logic [2:0] len);
    logic [4:0] kind;
    kind = K_IDENT;
    for (int k = 0; k < KW_NUM; k++) begin
      if (alive[k] && len == KW_LEN[k]) kind = K_IF + 5'(k);
    end
    return kind;
  endfunction

  function automatic stt_op_t single_op(logic [7:0] c);
    stt_op_t r;
    r.hit = 1'b1;
    case (c)
      "+":     r.kind = K_PLUS;
      "-":     r.kind = K_MINUS;
      "*":     r.kind = K_STAR;
      "%":     r.kind = K_PCT;
      "{":     r.kind = K_LBRACE;
      "}":     r.kind = K_RBRACE;
      "(":     r.kind = K_LPAREN;
      ")":     r.kind = K_RPAREN;
      ",":     r.kind = K_COMMA;
      "&":     r.kind = K_AMP;
      "?":     r.kind = K_QUEST;
      default: begin
        r.hit  = 1'b0;
        r.kind = K_UNKNOWN;
      end
    endcase
    return r;
  endfunction

  function automatic stt_pair_t pair_op(logic [7:0] c);
    stt_pair_t r;
    r.hit = 1'b1;
    case (c)
      CH_BANG: r.idx = POP_BANG;
      CH_EQ:   r.idx = POP_EQ;
      CH_GT:   r.idx = POP_GT;
      CH_LT:   r.idx = POP_LT;
      default: begin
        r.hit = 1'b0;
        r.idx = POP_BANG;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/stt_chan_if.sv]
// ----------------------------------------------------------------------------
// stt_in_if / stt_out_if
// Valid/ready channels of the tokenizer: source characters in, tokens out.
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       end_of_text;

  modport source (output valid, ch, has_char, end_of_text, input ready);
  modport sink   (input valid, ch, has_char, end_of_text, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_row;
  logic [15:0] start_col;
  logic [7:0]  token_length;
  logic        last_of_run;

  modport source (output valid, token_kind, start_row, start_col, token_length,
                  last_of_run, input ready);
  modport sink   (input valid, token_kind, start_row, start_col, token_length,
                  last_of_run, output ready);
endinterface

[rtl/stt_scan.sv]
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and the combinational step: takes one character word and gives
// up to three ordered tokens (pending flush, new token, eof).
// ----------------------------------------------------------------------------
module stt_scan #(
  parameter int MAX_TOKEN_LEN = 255,
  parameter int POS_BITS      = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       ch,
  input  logic             has_char,
  input  logic             end_of_text,
  output stt_pkg::stt_tok_t res [3],
  output logic [1:0]       n_res
);
  import stt_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [LEN_W-1:0]    LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
  localparam logic [LEN_W-1:0]    LEN_ONE = LEN_W'(1);
  localparam logic [LEN_W-1:0]    LEN_TWO = LEN_W'(2);

  stt_mode_t             mode_r, mode_mid, mode_nxt;
  logic [POS_BITS-1:0]   row_r, row_mid, row_nxt;
  logic [POS_BITS-1:0]   col_r, col_mid, col_nxt;
  logic [POS_BITS-1:0]   trow_r, trow_mid, trow_nxt;
  logic [POS_BITS-1:0]   tcol_r, tcol_mid, tcol_nxt;
  logic [LEN_W-1:0]      tlen_r, tlen_mid, tlen_nxt;
  logic [KW_NUM-1:0]     alive_r, alive_mid, alive_nxt;
  logic [1:0]            pop_r, pop_mid, pop_nxt;

  logic [POS_BITS-1:0]   row_inc, col_inc;
  logic [LEN_W-1:0]      len_inc;
  logic                  c_letter, c_digit;
  stt_op_t               sgl;
  stt_pair_t             pr;
  logic                  len_short_r, len_short_mid;
  logic [KW_NUM-1:0]     kw_hit_cur, kw_hit_first;
  logic [4:0]            ident_kind_r, ident_kind_mid;
  logic                  rescan;
  logic                  a_vld, b_vld, c_vld, m_vld;
  logic [4:0]            a_kind, b_kind, c_kind;
  logic [LEN_W-1:0]      a_len, c_len;
  stt_tok_t              ra, rm, re;

  // clamp a position to the 16-bit report field
  function automatic logic [15:0] pos_out(logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  // clamp a length to the 8-bit report field
  function automatic logic [7:0] len_out(logic [LEN_W-1:0] v);
    logic [15:0] w;
    w = 16'(v);
    return (w > 16'd255) ? 8'hFF : w[7:0];
  endfunction

  // saturating counters and character classes
  assign row_inc  = (row_r == POS_MAX) ? row_r : row_r + POS_ONE;
  assign col_inc  = (col_r == POS_MAX) ? col_r : col_r + POS_ONE;
  assign len_inc  = (tlen_r >= LEN_MAX) ? LEN_MAX : tlen_r + LEN_ONE;
  assign c_letter = is_letter(ch);
  assign c_digit  = is_digit(ch);
  assign sgl      = single_op(ch);
  assign pr       = pair_op(ch);

  // keyword tracking
  assign len_short_r    = (tlen_r >> 3) == '0;
  assign len_short_mid  = (tlen_mid >> 3) == '0;
  assign kw_hit_cur     = len_short_r ? kw_match(ch, tlen_r[2:0]) : '0;
  assign kw_hit_first   = kw_match(ch, 3'd0);
  assign ident_kind_r   = len_short_r ? kw_kind(alive_r, tlen_r[2:0]) : K_IDENT;
  assign ident_kind_mid = len_short_mid ? kw_kind(alive_mid, tlen_mid[2:0]) : K_IDENT;

  // character step: pending token first, then rescan in idle mode
  always_comb begin
    mode_mid  = mode_r;
    row_mid   = row_r;
    col_mid   = col_r;
    trow_mid  = trow_r;
    tcol_mid  = tcol_r;
    tlen_mid  = tlen_r;
    alive_mid = alive_r;
    pop_mid   = pop_r;
    rescan    = 1'b0;
    a_vld     = 1'b0;
    a_kind    = K_EOF;
    a_len     = LEN_ONE;
    b_vld     = 1'b0;
    b_kind    = K_EOF;
    if (has_char) begin
      case (mode_r)
        MODE_IDLE: rescan = 1'b1;
        MODE_IDENT: begin
          if (c_letter || c_digit) begin
            alive_mid = alive_r & kw_hit_cur;
            tlen_mid  = len_inc;
            col_mid   = col_inc;
          end else begin
            a_vld  = 1'b1;
            a_kind = ident_kind_r;
            a_len  = tlen_r;
            rescan = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (c_digit) begin
            tlen_mid = len_inc;
            col_mid  = col_inc;
          end else begin
            a_vld  = 1'b1;
            a_kind = K_INT;
            a_len  = tlen_r;
            rescan = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (ch == CH_SLASH) begin
            col_mid  = col_inc;
            mode_mid = MODE_COMMENT;
          end else begin
            a_vld  = 1'b1;
            a_kind = K_DIV;
            rescan = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (ch == CH_NL) begin
            row_mid  = row_inc;
            col_mid  = POS_ONE;
            mode_mid = MODE_IDLE;
          end else begin
            col_mid = col_inc;
          end
        end
        MODE_OP: begin
          if (ch == CH_EQ) begin
            col_mid  = col_inc;
            a_vld    = 1'b1;
            a_kind   = K_NOT + {2'b00, pop_r, 1'b1};
            a_len    = LEN_TWO;
            mode_mid = MODE_IDLE;
          end else begin
            a_vld  = 1'b1;
            a_kind = K_NOT + {2'b00, pop_r, 1'b0};
            rescan = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      if (rescan) begin
        mode_mid = MODE_IDLE;
        if (ch == CH_SPACE) begin
          col_mid = col_inc;
        end else if (ch == CH_NL) begin
          row_mid = row_inc;
          col_mid = POS_ONE;
        end else begin
          trow_mid = row_r;
          tcol_mid = col_r;
          tlen_mid = LEN_ONE;
          col_mid  = col_inc;
          if (ch == CH_SLASH) begin
            mode_mid = MODE_SLASH;
          end else if (c_letter) begin
            alive_mid = kw_hit_first;
            mode_mid  = MODE_IDENT;
          end else if (c_digit) begin
            mode_mid = MODE_NUMBER;
          end else if (sgl.hit) begin
            b_vld  = 1'b1;
            b_kind = sgl.kind;
          end else if (pr.hit) begin
            pop_mid  = pr.idx;
            mode_mid = MODE_OP;
          end else begin
            b_vld  = 1'b1;
            b_kind = K_UNKNOWN;
          end
        end
      end
    end
  end

  // end of text: flush what is still pending, then return to reset values
  always_comb begin
    c_vld  = 1'b0;
    c_kind = K_EOF;
    c_len  = LEN_ONE;
    case (mode_mid)
      MODE_IDENT: begin
        c_vld  = end_of_text;
        c_kind = ident_kind_mid;
        c_len  = tlen_mid;
      end
      MODE_NUMBER: begin
        c_vld  = end_of_text;
        c_kind = K_INT;
        c_len  = tlen_mid;
      end
      MODE_SLASH: begin
        c_vld  = end_of_text;
        c_kind = K_DIV;
      end
      MODE_OP: begin
        c_vld  = end_of_text;
        c_kind = K_NOT + {2'b00, pop_mid, 1'b0};
      end
      default: c_vld = 1'b0;
    endcase

    if (end_of_text) begin
      mode_nxt  = MODE_IDLE;
      row_nxt   = POS_ONE;
      col_nxt   = POS_ONE;
      trow_nxt  = POS_ONE;
      tcol_nxt  = POS_ONE;
      tlen_nxt  = '0;
      alive_nxt = '1;
      pop_nxt   = POP_BANG;
    end else begin
      mode_nxt  = mode_mid;
      row_nxt   = row_mid;
      col_nxt   = col_mid;
      trow_nxt  = trow_mid;
      tcol_nxt  = tcol_mid;
      tlen_nxt  = tlen_mid;
      alive_nxt = alive_mid;
      pop_nxt   = pop_mid;
    end
  end

  // candidate tokens in emission order
  assign m_vld = b_vld || c_vld;

  always_comb begin
    ra.kind = a_kind;
    ra.row  = pos_out(trow_r);
    ra.col  = pos_out(tcol_r);
    ra.len  = len_out(a_len);
    ra.last = !m_vld && !end_of_text;

    if (b_vld) begin
      rm.kind = b_kind;
      rm.row  = pos_out(row_r);
      rm.col  = pos_out(col_r);
      rm.len  = len_out(LEN_ONE);
    end else begin
      rm.kind = c_kind;
      rm.row  = pos_out(trow_mid);
      rm.col  = pos_out(tcol_mid);
      rm.len  = len_out(c_len);
    end
    rm.last = !end_of_text;

    re.kind = K_EOF;
    re.row  = pos_out(trow_mid);
    re.col  = pos_out(tcol_mid);
    re.len  = 8'd0;
    re.last = 1'b1;
  end

  // pack the valid candidates to the front
  always_comb begin
    res[0] = a_vld ? ra : (m_vld ? rm : re);
    res[1] = a_vld ? (m_vld ? rm : re) : re;
    res[2] = re;
    n_res  = {1'b0, a_vld} + {1'b0, m_vld} + {1'b0, end_of_text};
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      row_r   <= POS_ONE;
      col_r   <= POS_ONE;
      trow_r  <= POS_ONE;
      tcol_r  <= POS_ONE;
      tlen_r  <= '0;
      alive_r <= '1;
      pop_r   <= POP_BANG;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      trow_r  <= trow_nxt;
      tcol_r  <= tcol_nxt;
      tlen_r  <= tlen_nxt;
      alive_r <= alive_nxt;
      pop_r   <= pop_nxt;
    end
  end

`ifndef SYNTH
  // end of text leaves the scanner at the start of a fresh text
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && end_of_text) |=>
      (mode_r == MODE_IDLE && row_r == POS_ONE && col_r == POS_ONE && tlen_r == '0))
    else $error("scanner state not cleared after end of text");

  // end of text always yields at least the eof token
  a_end_gives_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && end_of_text) |-> (n_res != 2'd0 && res[n_res - 2'd1].kind == K_EOF))
    else $error("end of text without eof token");

  // a new token and an end-of-text flush never come from the same word
  a_mid_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> !(b_vld && c_vld))
    else $error("new token and flush in one word");
`endif

endmodule

[rtl/stt_outq.sv]
// ----------------------------------------------------------------------------
// stt_outq
// Four-entry token queue between the scanner and the result channel. Takes
// up to three tokens per word and gives one per cycle while the channel is ready.
// ----------------------------------------------------------------------------
module stt_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stt_pkg::stt_tok_t res [3],
  input  logic [1:0]        n_res,
  output logic              in_ready,
  stt_out_if.source         out_chan
);
  import stt_pkg::*;

  localparam int QDEPTH = 4;

  stt_tok_t    q_r   [QDEPTH];
  stt_tok_t    q_nxt [QDEPTH];
  logic [2:0]  count_r, count_nxt;
  logic [2:0]  rem;
  logic        pop;
  logic [1:0]  tail_idx;

  // head of queue drives the channel
  assign out_chan.valid        = count_r != 3'd0;
  assign out_chan.token_kind   = q_r[0].kind;
  assign out_chan.start_row    = q_r[0].row;
  assign out_chan.start_col    = q_r[0].col;
  assign out_chan.token_length = q_r[0].len;
  assign out_chan.last_of_run  = q_r[0].last;

  assign pop      = out_chan.valid && out_chan.ready;
  assign rem      = count_r - {2'b00, pop};
  assign in_ready = count_r <= 3'd1;
  assign tail_idx = 2'(count_r - 3'd1);

  // shift out the head, append the new run behind what remains
  always_comb begin
    logic [2:0] j;
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
      j = 3'(i) - rem;
      if (3'(i) < rem) begin
        q_nxt[i] = q_r[2'(i) + {1'b0, pop}];
      end else if (push && j < {1'b0, n_res}) begin
        q_nxt[i] = res[j[1:0]];
      end
    end
    count_nxt = rem + (push ? {1'b0, n_res} : 3'd0);
  end

  // queue storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  // fill never passes the depth
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(QDEPTH))
    else $error("token queue overflow");

  // whole runs only: the newest entry closes its run
  a_tail_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != 3'd0) |-> q_r[tail_idx].last)
    else $error("token queue holds a partial run");

  // a push lands on room for the largest run
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (rem + {1'b0, n_res} <= 3'(QDEPTH)))
    else $error("push without room");
`endif

endmodule

[rtl/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: one source character per word in, one token per word
// out, with kind, start row and column, and length.
// ----------------------------------------------------------------------------
// Each input word is scanned combinationally and its tokens (none, or up to
// three: a flushed pending token, a new one-character token and EOF) go into
// a four-entry result queue that drains one token per cycle while the output
// is ready. The input is ready whenever the queue holds at most one token, so
// a stream whose words each give at most one token runs at one character per
// cycle while the output is ready, even with a token waiting there; the queue
// drain rate is what sets the sustained rate. Tokens are registered in the
// queue and reach the output in order, after any tokens already waiting.
module source_text_tokenizer #(
  parameter int MAX_TOKEN_LEN = 255,
  parameter int POS_BITS      = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_chan,
  stt_out_if.source out_chan
);
  import stt_pkg::*;

  logic      acc;
  logic      in_ready;
  stt_tok_t  res [3];
  logic [1:0] n_res;

  // input handshake
  assign in_chan.ready = in_ready;
  assign acc           = in_chan.valid && in_ready;

  // character scanner
  stt_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .POS_BITS      (POS_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .ch          (in_chan.ch),
    .has_char    (in_chan.has_char),
    .end_of_text (in_chan.end_of_text),
    .res         (res),
    .n_res       (n_res)
  );

  // token queue
  stt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc),
    .res      (res),
    .n_res    (n_res),
    .in_ready (in_ready),
    .out_chan (out_chan)
  );

endmodule
